// ===== hdl/ufhp_pkg.sv =====
// Shared types, codes and constants of the UDP frame header parser.
package ufhp_pkg;

  // Default bound on the domain length byte
  localparam int unsigned DOMAIN_CAPACITY_DEF = 255;

  // Shortest buffer accepted as a frame, the size of a complete IPv4 header
  localparam logic [16:0] MIN_FRAME = 17'd11;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Header bytes counted on top of the address field: type, port, length, CRLF
  localparam logic [8:0] HDR_FIXED = 9'd7;

  // Address type bytes
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] IPV4_BYTES  = 8'd4;
  localparam logic [7:0] IPV6_BYTES  = 8'd16;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  // Byte role tags
  localparam logic [2:0] ROLE_TYPE    = 3'd0;
  localparam logic [2:0] ROLE_DLEN    = 3'd1;
  localparam logic [2:0] ROLE_ADDR    = 3'd2;
  localparam logic [2:0] ROLE_PORT    = 3'd3;
  localparam logic [2:0] ROLE_LEN     = 3'd4;
  localparam logic [2:0] ROLE_CRLF    = 3'd5;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd6;
  localparam logic [2:0] ROLE_IGNORE  = 3'd7;

  // Address kinds
  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_IPV6    = 2'd1;
  localparam logic [1:0] KIND_DOMAIN  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // Status codes; the error latch uses the same codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MSG     = 2'd1;
  localparam logic [1:0] ST_PROTO_ERR   = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PH_TYPE    = 8'b0000_0001,
    PH_DLEN    = 8'b0000_0010,
    PH_ADDR    = 8'b0000_0100,
    PH_PORT    = 8'b0000_1000,
    PH_LEN     = 8'b0001_0000,
    PH_CRLF    = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_IGNORE  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  field_count;
    logic [16:0] total_count;
    logic [1:0]  kind;
    logic [7:0]  addr_len;
    logic [15:0] port;
    logic [15:0] length;
    logic [8:0]  header_len;
    logic [1:0]  error;
    logic        cr_ok;
  } state_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_echo;
    logic [7:0]  field_position;
    logic        frame_done;
    logic [1:0]  status;
    logic [1:0]  address_kind;
    logic [7:0]  address_length;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
    logic [8:0]  payload_start;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_TYPE,
    field_count: 8'd0,
    total_count: 17'd0,
    kind:        KIND_IPV4,
    addr_len:    8'd0,
    port:        16'd0,
    length:      16'd0,
    header_len:  9'd0,
    error:       ST_OK,
    cr_ok:       1'b0
  };

endpackage

// ===== hdl/ufhp_step.sv =====
// Per-byte next-state and result logic of the UDP frame header parser.
module ufhp_step import ufhp_pkg::*; #(
  parameter int unsigned DomainCapacity = DOMAIN_CAPACITY_DEF
) (
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output state_t     state_o,
  output result_t    result_o
);

  state_t      nxt;
  logic [2:0]  role;
  logic [7:0]  pos;
  logic        enter_port;
  logic [7:0]  fc_inc;
  logic [8:0]  addr_field;
  logic [16:0] size;
  logic [16:0] frame_need;
  logic [1:0]  status;

  assign fc_inc = state_i.field_count + 8'd1;

  // Advance the phase for one byte
  always_comb begin
    nxt        = state_i;
    role       = ROLE_IGNORE;
    pos        = 8'd0;
    enter_port = 1'b0;
    addr_field = 9'd0;
    unique case (state_i.phase)
      PH_TYPE: begin
        role            = ROLE_TYPE;
        nxt.field_count = 8'd0;
        if (byte_i == ATYP_IPV4) begin
          nxt.kind     = KIND_IPV4;
          nxt.addr_len = IPV4_BYTES;
          nxt.phase    = PH_ADDR;
        end else if (byte_i == ATYP_IPV6) begin
          nxt.kind     = KIND_IPV6;
          nxt.addr_len = IPV6_BYTES;
          nxt.phase    = PH_ADDR;
        end else if (byte_i == ATYP_DOMAIN) begin
          nxt.kind  = KIND_DOMAIN;
          nxt.phase = PH_DLEN;
        end else begin
          nxt.kind  = KIND_UNKNOWN;
          nxt.error = ST_UNSUPPORTED;
          nxt.phase = PH_IGNORE;
        end
      end
      PH_DLEN: begin
        role            = ROLE_DLEN;
        nxt.addr_len    = byte_i;
        nxt.field_count = 8'd0;
        if (byte_i == 8'd0) begin
          enter_port = 1'b1;
        end else begin
          nxt.phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        role            = ROLE_ADDR;
        pos             = state_i.field_count;
        nxt.field_count = fc_inc;
        if (fc_inc == state_i.addr_len) begin
          enter_port = 1'b1;
        end
      end
      PH_PORT: begin
        role     = ROLE_PORT;
        pos      = state_i.field_count;
        nxt.port = {state_i.port[7:0], byte_i};
        if (state_i.field_count != 8'd0) begin
          nxt.field_count = 8'd0;
          nxt.phase       = PH_LEN;
        end else begin
          nxt.field_count = fc_inc;
        end
      end
      PH_LEN: begin
        role       = ROLE_LEN;
        pos        = state_i.field_count;
        nxt.length = {state_i.length[7:0], byte_i};
        if (state_i.field_count != 8'd0) begin
          nxt.field_count = 8'd0;
          nxt.phase       = PH_CRLF;
        end else begin
          nxt.field_count = fc_inc;
        end
      end
      PH_CRLF: begin
        role = ROLE_CRLF;
        pos  = state_i.field_count;
        if (state_i.field_count == 8'd0) begin
          nxt.cr_ok       = (byte_i == CHAR_CR);
          nxt.field_count = 8'd1;
        end else begin
          if (!(state_i.cr_ok && byte_i == CHAR_LF) && state_i.error == ST_OK) begin
            nxt.error = ST_PROTO_ERR;
          end
          nxt.field_count = 8'd0;
          nxt.phase       = (state_i.length == 16'd0) ? PH_IGNORE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        role = ROLE_PAYLOAD;
        pos  = state_i.total_count[7:0] - state_i.header_len[7:0];
        if ({1'b0, state_i.total_count} + 18'd1 >=
            {9'd0, state_i.header_len} + {2'd0, state_i.length}) begin
          nxt.phase = PH_IGNORE;
        end
      end
      default: begin
        role      = ROLE_IGNORE;
        nxt.phase = PH_IGNORE;
      end
    endcase

    // Close the address field: latch header length, go to the port
    if (enter_port) begin
      addr_field      = (nxt.kind == KIND_DOMAIN) ? 9'd1 + {1'b0, nxt.addr_len}
                                                  : {1'b0, nxt.addr_len};
      nxt.header_len  = HDR_FIXED + addr_field;
      nxt.field_count = 8'd0;
      nxt.phase       = PH_PORT;
    end

    // Count bytes, saturating
    if (state_i.total_count != COUNT_MAX) begin
      nxt.total_count = state_i.total_count + 17'd1;
    end
  end

  assign size       = nxt.total_count;
  assign frame_need = {8'd0, nxt.header_len} + {1'b0, nxt.length};

  // Rank the checks at the last byte, first match wins
  always_comb begin
    if (size < MIN_FRAME) begin
      status = ST_BAD_MSG;
    end else if (nxt.error == ST_UNSUPPORTED) begin
      status = ST_UNSUPPORTED;
    end else if (nxt.kind == KIND_DOMAIN && {1'b0, nxt.addr_len} > 9'(DomainCapacity)) begin
      status = ST_BAD_MSG;
    end else if (nxt.phase != PH_PAYLOAD && nxt.phase != PH_IGNORE) begin
      status = ST_BAD_MSG;
    end else if (nxt.error == ST_PROTO_ERR) begin
      status = ST_PROTO_ERR;
    end else if (size < frame_need) begin
      status = ST_BAD_MSG;
    end else begin
      status = ST_OK;
    end
  end

  // Build the result beat and drop state at the end of a buffer
  always_comb begin
    result_o                = '0;
    result_o.byte_role      = role;
    result_o.byte_echo      = byte_i;
    result_o.field_position = pos;
    result_o.frame_done     = last_i;
    if (last_i) begin
      result_o.status = status;
      if (status == ST_OK) begin
        result_o.address_kind   = nxt.kind;
        result_o.address_length = nxt.addr_len;
        result_o.dest_port      = nxt.port;
        result_o.payload_length = nxt.length;
        result_o.payload_start  = nxt.header_len;
      end
    end
    state_o = last_i ? STATE_RESET : nxt;
  end

endmodule

// ===== hdl/udp_frame_header_parser.sv =====
// UDP frame header parser: tags each byte of a frame and reports header status.
// A byte accepted into the input register moves on into the result register,
// which drives the output beat. Throughput: one byte per cycle while the output
// is not stalled; the input register and the result register let a new byte
// enter while a finished result waits on the output.
// Reset: rst_ni clears parser state and both valid flags; the next byte is a type byte.
module udp_frame_header_parser import ufhp_pkg::*; #(
  parameter int unsigned DomainCapacity = DOMAIN_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] byte_role, [10:3] byte_echo, [18:11] field_position, [20:19] status,
  // [22:21] address_kind, [30:23] address_length, [46:31] dest_port,
  // [62:47] payload_length, [71:63] payload_start
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_go;

  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;

  // Move the held byte forward when the result register is free
  assign in_go         = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ufhp_step #(
    .DomainCapacity(DomainCapacity)
  ) u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .result_o(res_d)
  );

  // Parser state advances once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_go) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.frame_done;
  assign m_axis_tdata  = {res_q.payload_start, res_q.payload_length, res_q.dest_port,
                          res_q.address_length, res_q.address_kind, res_q.status,
                          res_q.field_position, res_q.byte_echo, res_q.byte_role};

  // The parser restarts at a type byte after the last byte of a buffer
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_go && in_last_q |=> state_q.phase == PH_TYPE)
    else $error("parser did not restart after last byte");

  // A waiting input byte is not overwritten
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_go |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("held input byte changed");

  // Success is never reported for an unknown address type
  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done && res_q.status == ST_OK |->
      res_q.address_kind != KIND_UNKNOWN)
    else $error("success with unknown address kind");

  // Mid-buffer results carry no status
  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.frame_done |-> res_q.status == ST_OK && res_q.dest_port == 16'd0)
    else $error("status on a mid-buffer result");

endmodule

// ===== tb/sv/udp_frame_header_parser_test.sv =====
// Self-checking testbench for the UDP frame header parser with a byte-level parser model.
module udp_frame_header_parser_test;
  import ufhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned LONG_HOLD_AT = 150;
  localparam int unsigned RANDOM_BYTES = 100;
  localparam int unsigned SETTLE       = 10;

  // One input beat waiting for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] gap;
    logic       drain;
  } in_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] byte_role, [10:3] byte_echo, [18:11] field_position, [20:19] status,
  // [22:21] address_kind, [30:23] address_length, [46:31] dest_port,
  // [62:47] payload_length, [71:63] payload_start
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  udp_frame_header_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  in_beat_t    byte_queue[$];
  result_t     expected_tags[$];
  logic [7:0]  frame_buf[$];

  int unsigned err_count = 0;
  int unsigned out_count = 0;
  int unsigned byte_count = 0;
  int unsigned frame_count = 0;
  int unsigned drain_count = 0;
  int unsigned cycle_count = 0;
  int unsigned status_count[4];
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic        gap_armed = 1'b0;
  int unsigned gap_left = 0;
  int unsigned rx_wait = 0;
  bit          rx_quiet;

  // Parser model state
  logic [2:0]  prs_phase;
  logic [7:0]  prs_fcnt;
  logic [16:0] prs_total;
  logic [1:0]  prs_kind;
  logic [7:0]  prs_alen;
  logic [15:0] prs_port;
  logic [15:0] prs_plen;
  logic [8:0]  prs_hdr;
  logic [1:0]  prs_err;
  logic        prs_cr;

  task automatic parser_clear();
    prs_phase = ROLE_TYPE;
    prs_fcnt  = 8'd0;
    prs_total = 17'd0;
    prs_kind  = KIND_IPV4;
    prs_alen  = 8'd0;
    prs_port  = 16'd0;
    prs_plen  = 16'd0;
    prs_hdr   = 9'd0;
    prs_err   = ST_OK;
    prs_cr    = 1'b0;
  endtask

  // Close the address field and size the header
  task automatic parser_enter_port();
    logic [8:0] addr_field;
    addr_field = (prs_kind == KIND_DOMAIN) ? 9'(prs_alen) + 9'd1 : 9'(prs_alen);
    prs_hdr   = HDR_FIXED + addr_field;
    prs_fcnt  = 8'd0;
    prs_phase = ROLE_PORT;
  endtask

  // Advance the parser model by one byte and build the tag it produces
  task automatic parse_byte(input logic [7:0] b, input logic fin, output result_t r);
    int unsigned idx;
    int unsigned size;
    logic [1:0]  st;
    idx = prs_total;
    r = '0;
    r.byte_role = prs_phase;
    r.byte_echo = b;
    case (prs_phase)
      ROLE_TYPE: begin
        prs_fcnt = 8'd0;
        if (b == ATYP_IPV4) begin
          prs_kind = KIND_IPV4; prs_alen = IPV4_BYTES; prs_phase = ROLE_ADDR;
        end else if (b == ATYP_IPV6) begin
          prs_kind = KIND_IPV6; prs_alen = IPV6_BYTES; prs_phase = ROLE_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          prs_kind = KIND_DOMAIN; prs_phase = ROLE_DLEN;
        end else begin
          prs_kind = KIND_UNKNOWN; prs_err = ST_UNSUPPORTED; prs_phase = ROLE_IGNORE;
        end
      end
      ROLE_DLEN: begin
        prs_alen = b;
        prs_fcnt = 8'd0;
        if (b == 8'd0) parser_enter_port();
        else prs_phase = ROLE_ADDR;
      end
      ROLE_ADDR: begin
        r.field_position = prs_fcnt;
        prs_fcnt = prs_fcnt + 8'd1;
        if (prs_fcnt == prs_alen) parser_enter_port();
      end
      ROLE_PORT: begin
        r.field_position = prs_fcnt;
        prs_port = {prs_port[7:0], b};
        prs_fcnt = prs_fcnt + 8'd1;
        if (prs_fcnt >= 8'd2) begin
          prs_fcnt = 8'd0; prs_phase = ROLE_LEN;
        end
      end
      ROLE_LEN: begin
        r.field_position = prs_fcnt;
        prs_plen = {prs_plen[7:0], b};
        prs_fcnt = prs_fcnt + 8'd1;
        if (prs_fcnt >= 8'd2) begin
          prs_fcnt = 8'd0; prs_phase = ROLE_CRLF;
        end
      end
      ROLE_CRLF: begin
        r.field_position = prs_fcnt;
        if (prs_fcnt == 8'd0) begin
          prs_cr = (b == CHAR_CR);
          prs_fcnt = 8'd1;
        end else begin
          if (!(prs_cr && b == CHAR_LF) && prs_err == ST_OK) prs_err = ST_PROTO_ERR;
          prs_fcnt = 8'd0;
          prs_phase = (prs_plen == 16'd0) ? ROLE_IGNORE : ROLE_PAYLOAD;
        end
      end
      ROLE_PAYLOAD: begin
        r.field_position = 8'(idx - prs_hdr);
        if (idx + 1 >= prs_hdr + prs_plen) prs_phase = ROLE_IGNORE;
      end
      default: begin
        r.byte_role = ROLE_IGNORE;
        prs_phase = ROLE_IGNORE;
      end
    endcase

    // Saturate the buffer byte count
    if (prs_total < COUNT_MAX) prs_total = prs_total + 17'd1;
    size = prs_total;

    // Resolve status on the closing byte, first failing check wins
    if (fin) begin
      if (size < MIN_FRAME) st = ST_BAD_MSG;
      else if (prs_err == ST_UNSUPPORTED) st = ST_UNSUPPORTED;
      else if (prs_kind == KIND_DOMAIN && prs_alen > DOMAIN_CAPACITY_DEF) st = ST_BAD_MSG;
      else if (prs_phase != ROLE_PAYLOAD && prs_phase != ROLE_IGNORE) st = ST_BAD_MSG;
      else if (prs_err == ST_PROTO_ERR) st = ST_PROTO_ERR;
      else if (size < prs_hdr + prs_plen) st = ST_BAD_MSG;
      else st = ST_OK;
      r.frame_done = 1'b1;
      r.status = st;
      if (st == ST_OK) begin
        r.address_kind   = prs_kind;
        r.address_length = prs_alen;
        r.dest_port      = prs_port;
        r.payload_length = prs_plen;
        r.payload_start  = prs_hdr;
      end
      status_count[st]++;
      parser_clear();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
             out_count, what, want, got);
    err_count++;
  endtask

  task automatic check_result(input result_t want, input result_t got);
    if (got.byte_role !== want.byte_role)
      report_mismatch("byte_role", want.byte_role, got.byte_role);
    if (got.byte_echo !== want.byte_echo)
      report_mismatch("byte_echo", want.byte_echo, got.byte_echo);
    if (got.field_position !== want.field_position)
      report_mismatch("field_position", want.field_position, got.field_position);
    if (got.frame_done !== want.frame_done)
      report_mismatch("frame_done", want.frame_done, got.frame_done);
    if (got.status !== want.status)
      report_mismatch("status", want.status, got.status);
    if (got.address_kind !== want.address_kind)
      report_mismatch("address_kind", want.address_kind, got.address_kind);
    if (got.address_length !== want.address_length)
      report_mismatch("address_length", want.address_length, got.address_length);
    if (got.dest_port !== want.dest_port)
      report_mismatch("dest_port", want.dest_port, got.dest_port);
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", want.payload_length, got.payload_length);
    if (got.payload_start !== want.payload_start)
      report_mismatch("payload_start", want.payload_start, got.payload_start);
  endtask

  // Move the first n bytes of the frame buffer into the beat queue
  task automatic queue_frame(input int unsigned n, input bit drain);
    bit       quiet;
    in_beat_t bt;
    quiet = ($urandom_range(0, 3) == 0);
    if (n > frame_buf.size()) n = frame_buf.size();
    for (int unsigned i = 0; i < n; i++) begin
      bt.data  = frame_buf[i];
      bt.last  = (i == n - 1);
      bt.gap   = quiet ? 3'd0 : 3'($urandom_range(0, 7));
      bt.drain = drain && (i == 0);
      byte_queue = {byte_queue, bt};
    end
    byte_count += n;
    frame_count++;
  endtask

  // Assemble a frame: type, optional domain length, address, port, length, CRLF, body
  task automatic add_frame(input logic [7:0] atyp, input int unsigned dlen,
                           input logic [15:0] port, input logic [15:0] plen,
                           input logic [7:0] cr, input logic [7:0] lf,
                           input int unsigned body, input int unsigned cut,
                           input bit drain);
    int unsigned alen;
    frame_buf.delete();
    frame_buf = {frame_buf, atyp};
    if (atyp == ATYP_IPV4) alen = IPV4_BYTES;
    else if (atyp == ATYP_IPV6) alen = IPV6_BYTES;
    else begin
      alen = dlen;
      if (atyp == ATYP_DOMAIN) frame_buf = {frame_buf, 8'(dlen)};
    end
    for (int unsigned i = 0; i < alen; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    frame_buf = {frame_buf, port[15:8]};
    frame_buf = {frame_buf, port[7:0]};
    frame_buf = {frame_buf, plen[15:8]};
    frame_buf = {frame_buf, plen[7:0]};
    frame_buf = {frame_buf, cr};
    frame_buf = {frame_buf, lf};
    for (int unsigned i = 0; i < body; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    queue_frame((cut == 0) ? frame_buf.size() : cut, drain);
  endtask

  function automatic logic [7:0] pick_atyp();
    case ($urandom_range(0, 2))
      0: pick_atyp = ATYP_IPV4;
      1: pick_atyp = ATYP_IPV6;
      default: pick_atyp = ATYP_DOMAIN;
    endcase
  endfunction

  // Stimulus: directed frames, then random frames until the byte budget is spent
  initial begin
    int unsigned pick;
    int unsigned plen;
    int unsigned dlen;
    int unsigned start_bytes;
    logic [7:0]  atyp;
    logic [7:0]  cr;
    logic [7:0]  lf;
    for (int i = 0; i < 4; i++) status_count[i] = 0;
    parser_clear();

    // Lone bytes: a short buffer with a valid and with an unknown type
    frame_buf.delete(); frame_buf = {frame_buf, ATYP_IPV4}; queue_frame(1, 0);
    frame_buf.delete(); frame_buf = {frame_buf, 8'hFF}; queue_frame(1, 0);
    // Unknown type over a full-size buffer
    add_frame(8'h00, 4, 16'h1234, 16'd1, CHAR_CR, CHAR_LF, 1, 0, 0);
    // Good IPv4 and IPv6 frames, port extremes, trailing bytes after the payload
    add_frame(ATYP_IPV4, 0, 16'h0000, 16'd1, CHAR_CR, CHAR_LF, 1, 0, 0);
    add_frame(ATYP_IPV6, 0, 16'hFFFF, 16'd2, CHAR_CR, CHAR_LF, 4, 0, 0);
    // Empty domain, padded up to the minimum size
    add_frame(ATYP_DOMAIN, 0, 16'h8001, 16'd0, CHAR_CR, CHAR_LF, 3, 0, 0);
    // Exactly the minimum size with no payload
    add_frame(ATYP_IPV4, 0, 16'h00FF, 16'd0, CHAR_CR, CHAR_LF, 0, 0, 0);
    // Broken CR, then broken LF
    add_frame(ATYP_DOMAIN, 5, 16'h0050, 16'd2, 8'h0A, CHAR_LF, 2, 0, 0);
    add_frame(ATYP_IPV4, 0, 16'h0035, 16'd1, CHAR_CR, 8'h0D, 1, 0, 0);
    // Header cut short, payload cut short
    add_frame(ATYP_IPV6, 0, 16'h0101, 16'd3, CHAR_CR, CHAR_LF, 3, 20, 0);
    add_frame(ATYP_IPV4, 0, 16'hABCD, 16'hFFFF, CHAR_CR, CHAR_LF, 5, 0, 0);
    // Longest domain, issued only once the parser has drained
    add_frame(ATYP_DOMAIN, 255, 16'h7FFF, 16'd0, CHAR_CR, CHAR_LF, 0, 0, 1);

    // Mostly well-formed frames with random content, the rest broken or noise
    start_bytes = byte_count;
    while (byte_count - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      atyp = pick_atyp();
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      plen = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 16);
      cr = CHAR_CR;
      lf = CHAR_LF;
      if (pick < 60) begin
        add_frame(atyp, dlen, 16'($urandom_range(0, 65535)), 16'(plen), cr, lf,
                  plen + $urandom_range(0, 3), 0, (frame_count % 9) == 4);
      end else if (pick < 70) begin
        if ($urandom_range(0, 1)) cr = CHAR_CR ^ 8'($urandom_range(1, 255));
        else lf = CHAR_LF ^ 8'($urandom_range(1, 255));
        add_frame(atyp, dlen, 16'($urandom_range(0, 65535)), 16'(plen), cr, lf,
                  plen, 0, 0);
      end else if (pick < 80) begin
        add_frame(atyp, dlen, 16'($urandom_range(0, 65535)), 16'(plen), cr, lf,
                  plen, $urandom_range(1, 24), 0);
      end else if (pick < 88) begin
        add_frame(atyp, dlen, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(20, 65535)), cr, lf, $urandom_range(0, 8), 0, 0);
      end else begin
        frame_buf.delete();
        for (int unsigned i = $urandom_range(1, 24); i > 0; i--)
          frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
        queue_frame(frame_buf.size(), 0);
      end
    end

    // Hold reset, then let the driver run
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_queue.size() != 0 || s_axis_tvalid || expected_tags.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (expected_tags.size() != 0)
      report_mismatch("results never delivered", expected_tags.size(), 0);

    $display("covered %0d buffers in %0d bytes: %0d good, %0d bad message, %0d protocol",
             frame_count, byte_count, status_count[ST_OK], status_count[ST_BAD_MSG],
             status_count[ST_PROTO_ERR]);
    $display("  error, %0d unsupported; one %0d-cycle output hold, %0d drain pauses",
             status_count[ST_UNSUPPORTED], LONG_HOLD, drain_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_tags.size());
    $display("FAIL");
    $finish;
  end

  // Sample both handshakes: check delivered tags, predict accepted bytes
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      in_taken  <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_role      = m_axis_tdata[2:0];
        got.byte_echo      = m_axis_tdata[10:3];
        got.field_position = m_axis_tdata[18:11];
        got.frame_done     = m_axis_tlast;
        got.status         = m_axis_tdata[20:19];
        got.address_kind   = m_axis_tdata[22:21];
        got.address_length = m_axis_tdata[30:23];
        got.dest_port      = m_axis_tdata[46:31];
        got.payload_length = m_axis_tdata[62:47];
        got.payload_start  = m_axis_tdata[71:63];
        if (expected_tags.size() == 0) begin
          report_mismatch("result with nothing pending", 0, m_axis_tdata[10:3]);
        end else begin
          want = expected_tags.pop_front();
          check_result(want, got);
        end
        out_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast, want);
        expected_tags = {expected_tags, want};
      end
    end
  end

  // Input driver: wait out each beat's gap, hold the beat until it is taken
  always @(negedge clk_i) begin
    logic next_valid;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      next_valid = 1'b0;
      if (byte_queue.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = byte_queue[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(byte_queue[0].drain && expected_tags.size() != 0)) begin
          if (byte_queue[0].drain) drain_count++;
          s_axis_tdata <= byte_queue[0].data;
          s_axis_tlast <= byte_queue[0].last;
          void'(byte_queue.pop_front());
          gap_armed  = 1'b0;
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Output receiver: random stall after each beat outside quiet stretches, one long hold-off mid-run
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_quiet = ((out_count / 64) % 4) == 3;
      if (out_taken) begin
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 7);
        if (out_count == LONG_HOLD_AT) rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

endmodule
